### hw/rtl/mfbr_pkg.sv
// Package with the transaction types and status codes of the MSB-first bit reader.
`timescale 1ns / 1ps
`default_nettype none

package mfbr_pkg;

	localparam int BYTE_BITS  = 8;
	localparam int FIELD_BITS = 32;
	localparam int COUNT_BITS = 6;

	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_READ = 1'b1;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_DROPPED = 2'd1;
	localparam logic [1:0] STATUS_REFUSED = 2'd2;

	typedef struct packed {
		logic                  kind;
		logic [BYTE_BITS-1:0]  byte_value;
		logic [COUNT_BITS-1:0] bit_count;
	} item_t;

	typedef struct packed {
		logic [FIELD_BITS-1:0] field_value;
		logic [1:0]            status;
	} result_t;

endpackage

`default_nettype wire

### hw/rtl/mfbr_field_take.sv
// Barrel extractor that takes the oldest bits of the store as a right-aligned field.
`timescale 1ns / 1ps
`default_nettype none

module mfbr_field_take #(
	parameter int STORE_BITS    = 64,
	parameter int MAX_READ_BITS = 32
) (
	input  wire logic [STORE_BITS-1:0]            src,
	input  wire logic [mfbr_pkg::COUNT_BITS-1:0]  width,
	output logic      [mfbr_pkg::FIELD_BITS-1:0]  value,
	output logic      [STORE_BITS-1:0]            rest
);

	localparam logic [mfbr_pkg::COUNT_BITS-1:0] MAX_W = mfbr_pkg::COUNT_BITS'(MAX_READ_BITS);

	logic [MAX_READ_BITS-1:0] top;
	logic [MAX_READ_BITS-1:0] aligned;

	// The oldest bit sits at the MSB of the store, so a field is the top slice
	// shifted down until its last bit lands at bit zero.
	assign top     = src[STORE_BITS-1 -: MAX_READ_BITS];
	assign aligned = top >> (MAX_W - width);
	assign value   = mfbr_pkg::FIELD_BITS'(aligned);
	assign rest    = src << width;

endmodule

`default_nettype wire

### hw/rtl/msb_first_bit_reader.sv
// Top level of the MSB-first bit reader: bit store, pending read and result buffer.
`timescale 1ns / 1ps
`default_nettype none

// Usage notes.
// The item channel (item_valid, item_stall, item) carries one transaction per
// arriving data byte or per field read request. A transaction is accepted at a
// rising edge with valid high and stall low. The result channel (result_valid,
// result_stall, result) carries zero or one result per item: a delivered field,
// a dropped-byte flag or a refused-read flag.
// Every item is processed in the cycle it is accepted by a single pass of
// append and barrel-extract logic against the bit store, so one item is taken
// per cycle while item stall is low; its result goes to the output or skid register.
// A read that finds too few bits is parked as the single pending read and
// completes on the byte that brings enough bits; that byte produces the result.
// The result side is a two-entry buffer: an output register and a skid
// register. While the receiver stalls, one more result can be absorbed; item
// stall rises only when the skid register is occupied, and falls in the cycle
// after the receiver takes the waiting result.
// Reset empties the bit store, clears the pending read and drops any buffered
// results. No clearing pass is needed; the block takes items right away.

module msb_first_bit_reader #(
	parameter int STORE_BITS    = 64,
	parameter int MAX_READ_BITS = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_stall,
	input  wire mfbr_pkg::item_t  item,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output mfbr_pkg::result_t     result
);

	localparam int HELD_BITS = $clog2(STORE_BITS + 1);
	localparam int CW        = mfbr_pkg::COUNT_BITS;

	localparam logic [HELD_BITS-1:0] BYTE_H   = HELD_BITS'(mfbr_pkg::BYTE_BITS);
	localparam logic [HELD_BITS-1:0] APP_TOP  = HELD_BITS'(STORE_BITS - mfbr_pkg::BYTE_BITS);
	localparam logic [HELD_BITS-1:0] STORE_H  = HELD_BITS'(STORE_BITS);
	localparam logic [CW-1:0]        MAX_W    = CW'(MAX_READ_BITS);

	// Architectural state.
	logic [STORE_BITS-1:0] store_q,   store_d;
	logic [HELD_BITS-1:0]  held_q,    held_d;
	logic                  pend_v_q,  pend_v_d;
	logic [CW-1:0]         pend_w_q,  pend_w_d;

	// Result buffer: output register plus one skid entry.
	logic                  out_valid_q;
	mfbr_pkg::result_t     out_q;
	logic                  skid_valid_q;
	mfbr_pkg::result_t     skid_q;

	logic                  item_fire;
	logic                  out_fire;
	logic                  res_v;
	mfbr_pkg::result_t     res;

	logic [CW-1:0]         n_sat;
	logic [STORE_BITS-1:0] byte_wide;
	logic [STORE_BITS-1:0] store_app;
	logic [HELD_BITS-1:0]  held_app;
	logic [STORE_BITS-1:0] take_src;
	logic [CW-1:0]         take_w;
	logic [mfbr_pkg::FIELD_BITS-1:0] take_value;
	logic [STORE_BITS-1:0] take_rest;

	assign item_stall   = skid_valid_q;
	assign item_fire    = item_valid && !item_stall;
	assign out_fire     = out_valid_q && !result_stall;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	// Oversized widths saturate to the largest supported read.
	assign n_sat = (item.bit_count > MAX_W) ? MAX_W : item.bit_count;

	// The new byte goes right behind the last held bit. Only used when the
	// byte fits, so the shift amount never underflows.
	assign byte_wide = STORE_BITS'(item.byte_value);
	assign store_app = store_q | (byte_wide << (APP_TOP - held_q));
	assign held_app  = held_q + BYTE_H;

	// One extractor serves both the direct read and the pending read that a
	// byte completes; the source is the store after the append in that case.
	assign take_src = (item.kind == mfbr_pkg::KIND_BYTE) ? store_app : store_q;
	assign take_w   = (item.kind == mfbr_pkg::KIND_BYTE) ? pend_w_q : n_sat;

	mfbr_field_take #(
		.STORE_BITS    (STORE_BITS),
		.MAX_READ_BITS (MAX_READ_BITS)
	) u_take (
		.src   (take_src),
		.width (take_w),
		.value (take_value),
		.rest  (take_rest)
	);

	always_comb begin
		store_d             = store_q;
		held_d              = held_q;
		pend_v_d            = pend_v_q;
		pend_w_d            = pend_w_q;
		res_v               = 1'b0;
		res.field_value     = '0;
		res.status          = mfbr_pkg::STATUS_OK;
		if (item_fire) begin
			if (item.kind == mfbr_pkg::KIND_BYTE) begin
				if (held_q > APP_TOP) begin
					// Fewer than eight free bits: the byte is lost.
					res_v      = 1'b1;
					res.status = mfbr_pkg::STATUS_DROPPED;
				end else if (pend_v_q && (held_app >= HELD_BITS'(pend_w_q))) begin
					store_d         = take_rest;
					held_d          = held_app - HELD_BITS'(pend_w_q);
					pend_v_d        = 1'b0;
					pend_w_d        = '0;
					res_v           = 1'b1;
					res.field_value = take_value;
				end else begin
					store_d = store_app;
					held_d  = held_app;
				end
			end else begin
				if (pend_v_q) begin
					res_v      = 1'b1;
					res.status = mfbr_pkg::STATUS_REFUSED;
				end else if (n_sat == '0) begin
					res_v = 1'b1;
				end else if (held_q >= HELD_BITS'(n_sat)) begin
					store_d         = take_rest;
					held_d          = held_q - HELD_BITS'(n_sat);
					res_v           = 1'b1;
					res.field_value = take_value;
				end else begin
					pend_v_d = 1'b1;
					pend_w_d = n_sat;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_q  <= '0;
			held_q   <= '0;
			pend_v_q <= 1'b0;
			pend_w_q <= '0;
		end else begin
			store_q  <= store_d;
			held_q   <= held_d;
			pend_v_q <= pend_v_d;
			pend_w_q <= pend_w_d;
		end
	end

	// Result buffer control. Items are stalled while the skid entry is full,
	// so a new result never meets an occupied skid register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_fire) begin
				skid_valid_q <= 1'b0;
			end
		end else if (res_v) begin
			if (!out_valid_q || out_fire) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_fire) begin
				out_q <= skid_q;
			end
		end else if (res_v) begin
			if (!out_valid_q || out_fire) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry holds a result while the output register is empty");

	a_held_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= STORE_H)
		else $error("held bit count exceeds the store size");

	a_pending_short: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q |-> (held_q < HELD_BITS'(pend_w_q)))
		else $error("pending read has enough bits but was not completed");

	a_pending_width: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q |-> ((pend_w_q != '0) && (pend_w_q <= MAX_W)))
		else $error("pending read width out of range");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && !result_stall) |=> (out_valid_q && !skid_valid_q))
		else $error("skid entry did not move into the output register");

endmodule

`default_nettype wire
